// ===== src/rbpm_pkg.sv =====
// Package for the row band pattern midpoint block.
// Holds the request and result types, register indexes and reset levels.
// No dependencies.
package rbpm_pkg;

    localparam int LEVEL_BITS    = 8;
    localparam int MIDPOINT_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    typedef logic [LEVEL_BITS-1:0] level_t;

    typedef struct packed {
        level_t sample;
        logic   last_in_row;
    } in_item_t;

    typedef struct packed {
        logic                     found;
        logic [MIDPOINT_BITS-1:0] midpoint;
    } out_item_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_LEVEL = 2'd2;

    localparam level_t OUTER_LEVEL_RESET  = 8'd0;
    localparam level_t EDGE_LEVEL_RESET   = 8'd255;
    localparam level_t CENTER_LEVEL_RESET = 8'd128;

endpackage

// ===== src/rbpm_match.sv =====
// Run pattern matcher: level registers, match state and the row result.
// Depends on rbpm_pkg.
module rbpm_match #(
    parameter int POSITION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  rbpm_pkg::in_item_t                 item,
    input  logic                               cfg_we,
    input  logic [rbpm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  rbpm_pkg::level_t                   cfg_data,
    output logic                               result_valid,
    output rbpm_pkg::out_item_t                result
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_OUTER  = 3'd1,
        ST_EDGE1  = 3'd2,
        ST_CENTER = 3'd3,
        ST_EDGE2  = 3'd4,
        ST_DONE   = 3'd5
    } stage_t;

    rbpm_pkg::level_t outer_reg, edge_reg, center_reg;

    stage_t                   stage_reg, stage_next, restart;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] first_reg, first_next;
    logic [POSITION_BITS-1:0] last_reg, last_next;
    logic                     seen_reg, seen_next;
    logic [POSITION_BITS:0]   mid_sum;
    logic [POSITION_BITS-1:0] mid_full;
    logic                     is_outer, is_edge, is_center;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg  <= rbpm_pkg::OUTER_LEVEL_RESET;
            edge_reg   <= rbpm_pkg::EDGE_LEVEL_RESET;
            center_reg <= rbpm_pkg::CENTER_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbpm_pkg::CFG_OUTER_LEVEL:  outer_reg  <= cfg_data;
                rbpm_pkg::CFG_EDGE_LEVEL:   edge_reg   <= cfg_data;
                rbpm_pkg::CFG_CENTER_LEVEL: center_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign is_outer  = (item.sample == outer_reg);
    assign is_edge   = (item.sample == edge_reg);
    assign is_center = (item.sample == center_reg);
    assign restart   = is_outer ? ST_OUTER : ST_IDLE;

    always_comb
    begin
        stage_next = stage_reg;
        first_next = first_reg;
        last_next  = last_reg;
        seen_next  = seen_reg;
        case (stage_reg)
            ST_OUTER:
            begin
                if (!is_outer)
                    stage_next = is_edge ? ST_EDGE1 : ST_IDLE;
            end
            ST_EDGE1:
            begin
                if (!is_edge)
                begin
                    if (is_center)
                    begin
                        stage_next = ST_CENTER;
                        first_next = pos_reg;
                        last_next  = pos_reg;
                    end
                    else
                        stage_next = restart;
                end
            end
            ST_CENTER:
            begin
                if (is_center)
                    last_next = pos_reg;
                else if (is_edge)
                    stage_next = ST_EDGE2;
                else
                    stage_next = restart;
            end
            ST_EDGE2:
            begin
                if (!is_edge)
                begin
                    if (is_outer)
                    begin
                        stage_next = ST_DONE;
                        seen_next  = 1'b1;
                    end
                    else
                        stage_next = ST_IDLE;
                end
            end
            ST_DONE: ;
            default: stage_next = restart;
        endcase
        pos_next = pos_reg + POSITION_BITS'(1);
    end

    assign mid_sum  = {1'b0, first_next} + {1'b0, last_next};
    assign mid_full = mid_sum[POSITION_BITS:1];

    assign result_valid    = step && item.last_in_row;
    assign result.found    = seen_next;
    assign result.midpoint = seen_next ? rbpm_pkg::MIDPOINT_BITS'(mid_full) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            pos_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_in_row)
            begin
                stage_reg <= ST_IDLE;
                pos_reg   <= '0;
                first_reg <= '0;
                last_reg  <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                stage_reg <= stage_next;
                pos_reg   <= pos_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                seen_reg  <= seen_next;
            end
        end
    end

    a_done_seen: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_DONE |-> seen_reg)
        else $error("done stage without pattern flag");

    a_seen_done: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> stage_reg == ST_DONE)
        else $error("pattern flag outside done stage");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.midpoint == '0)
        else $error("nonzero midpoint without pattern");

    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_in_row |=> stage_reg == ST_IDLE && pos_reg == '0)
        else $error("row state not cleared after last sample");

endmodule

// ===== src/rbpm_out_queue.sv =====
// Two-entry result queue: output register plus skid stage.
// Depends on rbpm_pkg.
module rbpm_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rbpm_pkg::out_item_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output rbpm_pkg::out_item_t out_data
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    rbpm_pkg::out_item_t out_data_reg, out_data_next;
    rbpm_pkg::out_item_t skid_data_reg, skid_data_next;
    logic                pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !pop)
        begin
            if (push)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            out_valid_next = push;
            if (push)
                out_data_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without head entry");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push into full queue");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && !skid_valid_reg && push |=> skid_valid_reg)
        else $error("stalled push not held in skid stage");

endmodule

// ===== src/row_band_pattern_midpoint.sv =====
// Top level of the row band pattern midpoint block.
// Depends on rbpm_pkg, rbpm_match and rbpm_out_queue.
//
// Usage:
//   Samples of a row arrive on the in_* channel (valid/stall); in_data.last_in_row
//   marks the final sample. Each request updates the run matcher, which looks
//   for the run sequence outer, edge, center, edge, outer. On the last sample
//   one result leaves on the out_* channel: found and the midpoint of the
//   center run, 0 when not found. Other samples give no result.
//   Throughput: one request per cycle while in_stall is low; the matcher state update
//   is a single compare-and-select step plus one add for the midpoint.
//   Output: the result is registered in the output register, or in the skid stage.
//   Stall: results sit in an output register backed by a skid stage; in_stall
//   rises only when both are occupied, so a row keeps flowing while one
//   result waits.
//   Configuration: cfg_we writes cfg_data to the level at cfg_index
//   (0 outer, 1 edge, 2 center); write only while idle. Index 3 is ignored.
//   Reset: levels return to 0, 255, 128, row state clears, queue empties.
module row_band_pattern_midpoint #(
    parameter int POSITION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rbpm_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rbpm_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [rbpm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  rbpm_pkg::level_t                  cfg_data
);

    logic                step;
    logic                result_valid;
    logic                queue_full;
    rbpm_pkg::out_item_t result;

    assign in_stall = queue_full;
    assign step     = in_valid && !queue_full;

    rbpm_match #(
        .POSITION_BITS(POSITION_BITS)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    rbpm_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
